@@ design/qau_pkg.sv @@
package qau_pkg;

   localparam int W   = 32;
   localparam int F   = 28;
   localparam int OPW = 3;
   localparam int STW = 2;
   localparam int HW  = 2 * W + 2;
   localparam int NW  = 2 * W + 1;
   localparam int RB  = (NW + 1) / 2;
   localparam int SW  = 2 * RB;
   localparam int DW  = W + F;
   localparam int TW  = RB + F;
   localparam int QB  = F + 1;

   localparam logic [OPW-1:0] OP_ADD  = OPW'(0);
   localparam logic [OPW-1:0] OP_SUB  = OPW'(1);
   localparam logic [OPW-1:0] OP_HAM  = OPW'(2);
   localparam logic [OPW-1:0] OP_MAG  = OPW'(3);
   localparam logic [OPW-1:0] OP_NORM = OPW'(4);

   localparam logic [STW-1:0] ST_OK   = STW'(0);
   localparam logic [STW-1:0] ST_SAT  = STW'(1);
   localparam logic [STW-1:0] ST_ZERO = STW'(2);

   typedef logic [W-1:0] comp_type;
   typedef logic [3:0][W-1:0] quat_type;

   typedef struct packed {
      logic [OPW-1:0] op;
      quat_type       p;
      quat_type       res;
      logic           sat;
   } track_type;

   localparam logic [1:0] HP_Q [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };

   localparam logic HP_N [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

   // {flag, value}
   function automatic logic [W:0] sat_fn(input logic [HW-1:0] v);
      logic           fits;
      logic [W-1:0]   lim;
      fits = (&v[HW-1:W-1]) | ~(|v[HW-1:W-1]);
      lim  = {v[HW-1], {(W-1){~v[HW-1]}}};
      return fits ? {1'b0, v[W-1:0]} : {1'b1, lim};
   endfunction

endpackage

@@ design/quaternion_arithmetic_unit_top.sv @@
// Channel  Dir  tdata (low bit up)                                   tuser
// req      in   first_a, first_x, first_y, first_z,                  operation
//               second_a, second_x, second_y, second_z
// rsp      out  result_a, result_x, result_y, result_z               status
//
// One word per cycle unless stalled; from acceptance to rsp_tvalid a word passes
// the front stages, the bit-per-stage square root (one stage per root bit), the
// bit-per-stage divider (one stage per quotient bit) and the output register.
// Reset clears all valid bits; no clearing pass is needed.
// A stalled result word freezes the whole pipe, so req_tready follows
// rsp_tready while the output register is full.
module quaternion_arithmetic_unit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,   // first_a, first_x, first_y, first_z, second_a..second_z
   input  logic [2:0]   req_tuser,   // operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // result_a, result_x, result_y, result_z
   output logic [1:0]   rsp_tuser    // status
);
   import qau_pkg::*;

   logic                en;
   quat_type            in_p, in_q;
   logic                fr_valid, sq_valid, dv_valid;
   track_type           fr_trk, sq_trk, dv_trk;
   logic [NW-1:0]       fr_n;
   logic [RB-1:0]       sq_mag, dv_mag;
   logic [3:0][QB-1:0]  dv_quot;
   logic                rsp_tvalid_ff;
   quat_type            res_ff, res_in;
   logic [STW-1:0]      st_ff, st_in;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   for (genvar c = 0; c < 4; c++) begin : g_unpack
      assign in_p[c] = req_tdata[c*W +: W];
      assign in_q[c] = req_tdata[(c+4)*W +: W];
   end

   qau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_op     (req_tuser),
      .in_p      (in_p),
      .in_q      (in_q),
      .out_valid (fr_valid),
      .out_trk   (fr_trk),
      .out_n     (fr_n)
   );

   qau_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_trk    (fr_trk),
      .in_n      (fr_n),
      .out_valid (sq_valid),
      .out_trk   (sq_trk),
      .out_mag   (sq_mag)
   );

   qau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_trk    (sq_trk),
      .in_mag    (sq_mag),
      .out_valid (dv_valid),
      .out_trk   (dv_trk),
      .out_mag   (dv_mag),
      .out_quot  (dv_quot)
   );

   always_comb begin
      logic magsat;
      magsat = |dv_mag[RB-1:W-1];
      res_in = dv_trk.res;
      st_in  = dv_trk.sat ? ST_SAT : ST_OK;
      unique case (dv_trk.op)
         OP_MAG: begin
            res_in    = '0;
            res_in[0] = magsat ? {1'b0, {(W-1){1'b1}}} : dv_mag[W-1:0];
            st_in     = magsat ? ST_SAT : ST_OK;
         end
         OP_NORM: begin
            st_in = ST_OK;
            for (int c = 0; c < 4; c++) begin
               res_in[c] = dv_trk.p[c][W-1] ? W'(0) - W'(dv_quot[c]) : W'(dv_quot[c]);
            end
            if (dv_mag == '0) begin
               res_in = '0;
               st_in  = ST_ZERO;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         st_ff  <= st_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = res_ff;
   assign rsp_tuser  = st_ff;

endmodule

@@ design/qau_front.sv @@
module qau_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [qau_pkg::OPW-1:0]   in_op,
   input  qau_pkg::quat_type         in_p,
   input  qau_pkg::quat_type         in_q,
   output logic                      out_valid,
   output qau_pkg::track_type        out_trk,
   output logic [qau_pkg::NW-1:0]    out_n
);
   import qau_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [OPW-1:0]       op1_ff, op2_ff, op3_ff;
   quat_type             p1_ff, p2_ff, p3_ff, q1_ff, q1_in;
   logic signed [2*W-1:0] prod2_ff [4][4];
   quat_type             as2_ff, as2_in, as3_ff;
   logic                 ass2_ff, ass2_in, ass3_ff;
   logic [HW-1:0]        h3_ff [4][2];
   logic [HW-1:0]        h3_in [4][2];
   logic [NW-1:0]        sq3_ff [2];
   logic [NW-1:0]        n4_ff, n4_in;
   track_type            trk4_ff, trk4_in;

   assign q1_in = (in_op == OP_MAG || in_op == OP_NORM) ? in_p : in_q;

   always_comb begin
      logic [HW-1:0] a, b, s;
      logic [W:0]    r;
      ass2_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         a = {{(HW-W){p1_ff[c][W-1]}}, p1_ff[c]};
         b = {{(HW-W){q1_ff[c][W-1]}}, q1_ff[c]};
         s = (op1_ff == OP_SUB) ? a - b : a + b;
         r = sat_fn(s);
         as2_in[c] = r[W-1:0];
         ass2_in = ass2_in | r[W];
      end
   end

   always_comb begin
      logic [HW-1:0] t [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            t[k] = HW'(prod2_ff[k][HP_Q[c][k]]);
            if (HP_N[c][k]) begin
               t[k] = HW'(0) - t[k];
            end
         end
         h3_in[c][0] = t[0] + t[1];
         h3_in[c][1] = t[2] + t[3];
      end
   end

   always_comb begin
      logic [HW-1:0] acc, sh;
      logic [W:0]    r;
      quat_type      ham;
      logic          hs;
      hs = 1'b0;
      for (int c = 0; c < 4; c++) begin
         acc = h3_ff[c][0] + h3_ff[c][1];
         sh  = HW'($signed(acc) >>> F);
         r   = sat_fn(sh);
         ham[c] = r[W-1:0];
         hs = hs | r[W];
      end
      n4_in = sq3_ff[0] + sq3_ff[1];
      trk4_in.op = op3_ff;
      trk4_in.p  = p3_ff;
      unique case (op3_ff)
         OP_ADD, OP_SUB: begin
            trk4_in.res = as3_ff;
            trk4_in.sat = ass3_ff;
         end
         OP_HAM: begin
            trk4_in.res = ham;
            trk4_in.sat = hs;
         end
         default: begin
            trk4_in.res = '0;
            trk4_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= in_op;
         p1_ff  <= in_p;
         q1_ff  <= q1_in;
         op2_ff <= op1_ff;
         p2_ff  <= p1_ff;
         as2_ff <= as2_in;
         ass2_ff <= ass2_in;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               prod2_ff[i][j] <= $signed(p1_ff[i]) * $signed(q1_ff[j]);
            end
         end
         op3_ff  <= op2_ff;
         p3_ff   <= p2_ff;
         as3_ff  <= as2_ff;
         ass3_ff <= ass2_ff;
         h3_ff   <= h3_in;
         sq3_ff[0] <= NW'(unsigned'(prod2_ff[0][0])) + NW'(unsigned'(prod2_ff[1][1]));
         sq3_ff[1] <= NW'(unsigned'(prod2_ff[2][2])) + NW'(unsigned'(prod2_ff[3][3]));
         n4_ff   <= n4_in;
         trk4_ff <= trk4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_trk   = trk4_ff;
   assign out_n     = n4_ff;

endmodule

@@ design/qau_sqrt.sv @@
module qau_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  qau_pkg::track_type        in_trk,
   input  logic [qau_pkg::NW-1:0]    in_n,
   output logic                      out_valid,
   output qau_pkg::track_type        out_trk,
   output logic [qau_pkg::RB-1:0]    out_mag
);
   import qau_pkg::*;

   logic [SW-1:0] rem_w  [RB+1];
   logic [RB-1:0] root_w [RB+1];
   track_type     trk_w  [RB+1];
   logic          v_w    [RB+1];
   logic [SW-1:0] rem_ff  [RB];
   logic [RB-1:0] root_ff [RB];
   track_type     trk_ff  [RB];
   logic          v_ff    [RB];

   assign rem_w[0]  = SW'(in_n);
   assign root_w[0] = '0;
   assign trk_w[0]  = in_trk;
   assign v_w[0]    = in_valid;

   for (genvar k = 0; k < RB; k++) begin : g_step
      localparam int I = RB - 1 - k;
      logic [SW-1:0] trial;
      logic          ge;
      assign trial = (SW'(root_w[k]) << (I + 1)) | (SW'(1) << (2 * I));
      assign ge    = rem_w[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? rem_w[k] - trial : rem_w[k];
            root_ff[k] <= ge ? root_w[k] | (RB'(1) << I) : root_w[k];
            trk_ff[k]  <= trk_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff[k];
      assign root_w[k+1] = root_ff[k];
      assign trk_w[k+1]  = trk_ff[k];
      assign v_w[k+1]    = v_ff[k];
   end

   assign out_valid = v_w[RB];
   assign out_trk   = trk_w[RB];
   assign out_mag   = root_w[RB];

endmodule

@@ design/qau_div.sv @@
module qau_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  qau_pkg::track_type        in_trk,
   input  logic [qau_pkg::RB-1:0]    in_mag,
   output logic                      out_valid,
   output qau_pkg::track_type        out_trk,
   output logic [qau_pkg::RB-1:0]    out_mag,
   output logic [3:0][qau_pkg::QB-1:0] out_quot
);
   import qau_pkg::*;

   logic [3:0][TW-1:0] rem_w  [QB+1];
   logic [3:0][QB-1:0] quot_w [QB+1];
   logic [RB-1:0]      mag_w  [QB+1];
   track_type          trk_w  [QB+1];
   logic               v_w    [QB+1];
   logic [3:0][TW-1:0] rem_ff  [QB];
   logic [3:0][QB-1:0] quot_ff [QB];
   logic [RB-1:0]      mag_ff  [QB];
   track_type          trk_ff  [QB];
   logic               v_ff    [QB];

   always_comb begin
      logic [W-1:0] a;
      for (int c = 0; c < 4; c++) begin
         a = in_trk.p[c][W-1] ? W'(0) - in_trk.p[c] : in_trk.p[c];
         rem_w[0][c] = TW'(a) << F;
      end
   end

   assign quot_w[0] = '0;
   assign mag_w[0]  = in_mag;
   assign trk_w[0]  = in_trk;
   assign v_w[0]    = in_valid;

   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int I = QB - 1 - k;
      logic [TW-1:0]      trial;
      logic [3:0][TW-1:0] rem_in;
      logic [3:0][QB-1:0] quot_in;
      assign trial = TW'(mag_w[k]) << I;

      always_comb begin
         for (int c = 0; c < 4; c++) begin
            if (rem_w[k][c] >= trial) begin
               rem_in[c]  = rem_w[k][c] - trial;
               quot_in[c] = quot_w[k][c] | (QB'(1) << I);
            end else begin
               rem_in[c]  = rem_w[k][c];
               quot_in[c] = quot_w[k][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            mag_ff[k]  <= mag_w[k];
            trk_ff[k]  <= trk_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff[k];
      assign quot_w[k+1] = quot_ff[k];
      assign mag_w[k+1]  = mag_ff[k];
      assign trk_w[k+1]  = trk_ff[k];
      assign v_w[k+1]    = v_ff[k];
   end

   assign out_valid = v_w[QB];
   assign out_trk   = trk_w[QB];
   assign out_mag   = mag_w[QB];
   assign out_quot  = quot_w[QB];

endmodule
